@@ hw/rtl/lcf_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcf_pkg
// shared widths, action codes, control types for the fir cell chain
// ---------------------------------------------------------------------------
package lcf_pkg;

    localparam int S_W   = 16;  // sample and coefficient width
    localparam int P_W   = 32;  // product width
    localparam int Y_W   = 35;  // result width
    localparam int IDX_W = 3;   // coefficient index width
    localparam int TC_W  = 4;   // tap count register width

    localparam logic [TC_W-1:0] TC_RESET = 4'd8;

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_END    = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_CALC
    } t_state;

    typedef struct packed {
        logic                    shift;
        logic                    clear;
        logic                    coef_we;
        logic [IDX_W-1:0]        coef_idx;
        logic signed [S_W-1:0]   coef_val;
    } t_cell_ctl;

endpackage

@@ hw/rtl/lcf_cell.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcf_cell
// one tap: delay stage, coefficient, registered product, partial sum stage
// ---------------------------------------------------------------------------
module lcf_cell
    import lcf_pkg::*;
#(
    parameter int K = 0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic signed [S_W-1:0] i_sample,
    output logic signed [S_W-1:0] o_sample,
    input  logic                  i_tap_en,
    input  logic signed [Y_W-1:0] i_acc,
    output logic signed [Y_W-1:0] o_acc
);

    localparam bit HIT_OK = (K < (1 << IDX_W));

    logic signed [S_W-1:0] r_dly;
    logic signed [S_W-1:0] r_coef;
    logic signed [P_W-1:0] r_prod;
    logic signed [Y_W-1:0] r_acc;
    logic signed [P_W-1:0] n_prod;
    logic signed [Y_W-1:0] n_acc;
    logic                  w_hit;

    assign w_hit  = HIT_OK && (i_ctl.coef_idx == IDX_W'(K));
    assign n_prod = r_dly * r_coef;
    assign n_acc  = i_acc + {{(Y_W-P_W){r_prod[P_W-1]}}, r_prod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly  <= '0;
            r_coef <= '0;
        end else begin
            if (i_ctl.clear) begin
                r_dly <= '0;
            end else if (i_ctl.shift) begin
                r_dly <= i_sample;
            end
            if (i_ctl.coef_we && w_hit) begin
                r_coef <= i_ctl.coef_val;
            end
        end
    end

    // unused taps add nothing
    always_ff @(posedge i_clk) begin
        r_prod <= i_tap_en ? n_prod : '0;
        r_acc  <= n_acc;
    end

    assign o_sample = r_dly;
    assign o_acc    = r_acc;

endmodule

@@ hw/rtl/linear_convolution_fir.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_convolution_fir
// direct form fir filter built as a chain of tap cells
// ---------------------------------------------------------------------------
// channel   direction  handshake               payload
// input     in         i_valid / o_ready       i_action i_coef_index
//                                              i_coef_value i_sample
// output    out        o_valid / i_ready       o_y o_last
// config    in         i_cfg_valid / o_cfg_ready  i_tap_count
//
// a load word or an unused action gives no result and leaves the input ready.
// a sample word gives one result: it enters the delay line, the product
// registers load, then the partial sum walks the cell chain one cell per
// cycle into the output register. an end word shifts in zeros for tap_count-1
// tail results, then clears the delay line; with one tap it only clears.
// reset zeroes delay line and coefficients and sets tap_count to 8.
// a stalled output holds the finished sum in the chain until the output
// register frees; the input is taken again only once the word is done.
// ---------------------------------------------------------------------------
module linear_convolution_fir
    import lcf_pkg::*;
#(
    parameter int TAPS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input words
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_action,
    input  logic [IDX_W-1:0]      i_coef_index,
    input  logic signed [S_W-1:0] i_coef_value,
    input  logic signed [S_W-1:0] i_sample,
    // result words
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [Y_W-1:0] o_y,
    output logic                  o_last,
    // tap count register
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [TC_W-1:0]       i_tap_count
);

    // counter runs from the shift to the cycle the last cell holds the sum
    localparam int CALC_LAST = TAPS + 1;
    localparam int CNT_W     = $clog2(TAPS + 2);
    localparam int TMAX      = (TAPS > 15) ? 15 : TAPS;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_flush, n_flush;
    logic [TC_W-1:0]       r_left, n_left;
    logic [TC_W-1:0]       r_tap_count;
    logic                  r_out_valid, n_out_valid;
    logic signed [Y_W-1:0] r_y, n_y;
    logic                  r_last, n_last;

    logic [TC_W-1:0]       w_taps;
    logic                  w_in_acc;
    logic                  w_out_free;
    t_cell_ctl             w_ctl;
    logic signed [S_W-1:0] w_shift_data;
    logic [TAPS-1:0]       w_tap_en;
    logic signed [S_W-1:0] w_dly [TAPS];
    logic signed [Y_W-1:0] w_acc [TAPS+1];

    // tap count in use, clamped to 1..TAPS and to at most 15
    always_comb begin
        if (r_tap_count == '0) begin
            w_taps = TC_W'(1);
        end else if (int'(r_tap_count) > TMAX) begin
            w_taps = TC_W'(TMAX);
        end else begin
            w_taps = r_tap_count;
        end
    end

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count <= TC_RESET;
        end else if (i_cfg_valid) begin
            r_tap_count <= i_tap_count;
        end
    end

    assign o_ready    = (r_state == S_IDLE);
    assign w_in_acc   = i_valid && o_ready;
    assign w_out_free = !r_out_valid || i_ready;

    // sequencer: next state, cell controls, output register load
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_flush      = r_flush;
        n_left       = r_left;
        n_out_valid  = r_out_valid && !i_ready;
        n_y          = r_y;
        n_last       = r_last;
        w_ctl        = '0;
        w_ctl.coef_idx = i_coef_index;
        w_ctl.coef_val = i_coef_value;
        w_shift_data = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_action)
                        ACT_LOAD: begin
                            w_ctl.coef_we = 1'b1;
                        end
                        ACT_SAMPLE: begin
                            w_ctl.shift  = 1'b1;
                            w_shift_data = i_sample;
                            n_flush      = 1'b0;
                            n_cnt        = '0;
                            n_state      = S_CALC;
                        end
                        ACT_END: begin
                            if (w_taps == TC_W'(1)) begin
                                // no tail, just clear
                                w_ctl.clear = 1'b1;
                            end else begin
                                w_ctl.shift = 1'b1;
                                n_flush     = 1'b1;
                                n_left      = w_taps - TC_W'(1);
                                n_cnt       = '0;
                                n_state     = S_CALC;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CALC: begin
                if (r_cnt != CNT_W'(CALC_LAST)) begin
                    n_cnt = r_cnt + CNT_W'(1);
                end else if (w_out_free) begin
                    // sum is in the last cell, hand it to the output register
                    n_out_valid = 1'b1;
                    n_y         = w_acc[TAPS];
                    n_last      = r_flush && (r_left == TC_W'(1));
                    if (!r_flush) begin
                        n_state = S_IDLE;
                    end else if (r_left == TC_W'(1)) begin
                        w_ctl.clear = 1'b1;
                        n_flush     = 1'b0;
                        n_state     = S_IDLE;
                    end else begin
                        // next tail output: shift in a zero
                        w_ctl.shift = 1'b1;
                        n_left      = r_left - TC_W'(1);
                        n_cnt       = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_flush     <= 1'b0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_flush     <= n_flush;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_y    <= n_y;
        r_last <= n_last;
    end

    assign o_valid = r_out_valid;
    assign o_y     = r_y;
    assign o_last  = r_last;

    // cell chain: samples move right on a shift, partial sums every cycle
    assign w_acc[0] = '0;
    genvar k;
    generate
        for (k = 0; k < TAPS; k++) begin : g_cell
            assign w_tap_en[k] = (k < int'(w_taps));
            lcf_cell #(
                .K(k)
            ) u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (w_ctl),
                .i_sample ((k == 0) ? w_shift_data : w_dly[(k == 0) ? 0 : k-1]),
                .o_sample (w_dly[k]),
                .i_tap_en (w_tap_en[k]),
                .i_acc    (w_acc[k]),
                .o_acc    (w_acc[k+1])
            );
        end
    endgenerate

endmodule
